>>> sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// shared constants, codes and control types of the text console writer
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    // screen geometry
    localparam int ROWS       = 25;
    localparam int COLUMNS    = 80;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = $clog2(COLUMNS + 1);
    localparam int CA_W  = $clog2(CELL_COUNT);
    localparam int OFF_W = $clog2(CELL_COUNT + 1);

    // item field widths
    localparam int FUNC_W   = 3;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 5;
    localparam int ADDR_W   = 11;
    localparam int CUROFF_W = 11;
    localparam int CELL_W   = 16;
    localparam int CLR_W    = 4;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_FG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_BG = 1'b1;

    localparam logic [CLR_W-1:0] DEF_FG_RST = 4'd7;
    localparam logic [CLR_W-1:0] DEF_BG_RST = 4'd0;

    // function codes
    localparam logic [FUNC_W-1:0] FN_PRINT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_COLOR = 3'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd2;
    localparam logic [FUNC_W-1:0] FN_HOME  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_READ  = 3'd4;

    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'd32;

    // start point of the sweep counter
    typedef enum logic [1:0] {
        CS_ZERO,
        CS_COPY,
        CS_LAST_ROW
    } t_cnt_start;

    typedef struct packed {
        logic       latch;
        logic       wrap;
        logic       put;
        logic       set_color;
        logic       home;
        logic       defaults;
        logic       cnt_load;
        t_cnt_start cnt_start;
        logic       copy;
        logic       fill;
        logic       fill_zero;
        logic       rd_cell;
        logic       load_out;
    } t_tcw_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              newline;
        logic              col_full;
        logic              last_row;
        logic              cnt_last;
        logic              out_free;
    } t_tcw_stat;

endpackage

`default_nettype wire

>>> sv/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// text-mode console: prints characters into a cell store with wrap and scroll
// ----------------------------------------------------------------------------
// One item is taken at a time and gives one result. After reset the block
// zeroes its ROWS*COLUMNS cell store before it takes the first item;
// configuration writes are taken meanwhile. A plain character passes
// decode, store write and result load; a colour, home, read, newline or
// unknown code passes decode and result load only. A wrap or newline on the
// last row scrolls: the copy sweep moves one cell a cycle, then the last row
// is filled, and a wrapping character is written after that; a clear-screen
// item walks every cell once.
// A held result stalls the next result load, not the acceptance of the item.
`default_nettype none

module text_console_writer (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // configuration write port
    input  wire                               i_cfg_we,
    input  wire  [tcw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [tcw_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // input items
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // func[2:0], char_code[10:3], color_code[15:11], cell_address[26:16]
    input  wire  [tcw_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // result items
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // cursor_offset[10:0], cell_data[26:11], foreground[30:27], background[34:31]
    output logic [tcw_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
    import tcw_pkg::*;

    t_tcw_cmd  w_cmd;
    t_tcw_stat w_stat;

    logic [CUROFF_W-1:0] w_cursor_offset;
    logic [CELL_W-1:0]   w_cell_data;
    logic [CLR_W-1:0]    w_foreground;
    logic [CLR_W-1:0]    w_background;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tcw_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_func          (s_axis_tdata[2:0]),
        .i_char_code     (s_axis_tdata[10:3]),
        .i_color_code    (s_axis_tdata[15:11]),
        .i_cell_address  (s_axis_tdata[26:16]),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_cursor_offset (w_cursor_offset),
        .o_cell_data     (w_cell_data),
        .o_foreground    (w_foreground),
        .o_background    (w_background)
    );

    assign m_axis_tdata = {5'd0, w_background, w_foreground, w_cell_data, w_cursor_offset};

endmodule

`default_nettype wire

>>> sv/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// sequencer: decodes each item and steps the datapath through print, scroll,
// fill, read and result phases
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  tcw_pkg::t_tcw_stat i_stat,
    output tcw_pkg::t_tcw_cmd  o_cmd
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_COPY,
        ST_DRAIN,
        ST_FILL,
        ST_PUT,
        ST_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_INIT: begin
                // zero the whole store after reset
                o_cmd.fill      = 1'b1;
                o_cmd.fill_zero = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_RESULT;
                unique case (i_stat.func)
                    FN_PRINT: begin
                        if (i_stat.newline || i_stat.col_full) begin
                            o_cmd.wrap = 1'b1;
                            if (i_stat.last_row) begin
                                o_cmd.cnt_load  = 1'b1;
                                o_cmd.cnt_start = CS_COPY;
                                n_state         = ST_COPY;
                            end else if (!i_stat.newline) begin
                                n_state = ST_PUT;
                            end
                        end else begin
                            n_state = ST_PUT;
                        end
                    end
                    FN_COLOR: begin
                        o_cmd.set_color = 1'b1;
                    end
                    FN_CLEAR: begin
                        o_cmd.home      = 1'b1;
                        o_cmd.cnt_load  = 1'b1;
                        o_cmd.cnt_start = CS_ZERO;
                        n_state         = ST_FILL;
                    end
                    FN_HOME: begin
                        o_cmd.home     = 1'b1;
                        o_cmd.defaults = 1'b1;
                    end
                    FN_READ: begin
                        o_cmd.rd_cell = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ST_COPY: begin
                o_cmd.copy = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last copy write lands here
                o_cmd.cnt_load  = 1'b1;
                o_cmd.cnt_start = CS_LAST_ROW;
                n_state         = ST_FILL;
            end
            ST_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_stat.cnt_last) begin
                    if (i_stat.func == FN_PRINT && !i_stat.newline) begin
                        n_state = ST_PUT;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // a result is only produced when the output register can take it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_stat.out_free)
        else $error("result loaded into a full output register");

    // scroll always runs copy, drain, fill in that order
    a_drain_to_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DRAIN |=> r_state == ST_FILL)
        else $error("scroll drain not followed by fill");

    // no item is taken while the store is being cleared after reset
    a_init_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_INIT |-> !o_in_ready)
        else $error("item accepted during initial clear");

endmodule

`default_nettype wire

>>> sv/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// cell store, cursor, colours, sweep counter and output register
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_datapath (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [tcw_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [tcw_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  wire  [tcw_pkg::FUNC_W-1:0]          i_func,
    input  wire  [tcw_pkg::CHAR_W-1:0]          i_char_code,
    input  wire  [tcw_pkg::COLOR_W-1:0]         i_color_code,
    input  wire  [tcw_pkg::ADDR_W-1:0]          i_cell_address,
    input  tcw_pkg::t_tcw_cmd                   i_cmd,
    output tcw_pkg::t_tcw_stat                  o_stat,
    input  wire                                 i_out_ready,
    output logic                                o_out_valid,
    output logic [tcw_pkg::CUROFF_W-1:0]        o_cursor_offset,
    output logic [tcw_pkg::CELL_W-1:0]          o_cell_data,
    output logic [tcw_pkg::CLR_W-1:0]           o_foreground,
    output logic [tcw_pkg::CLR_W-1:0]           o_background
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [CELL_COUNT];

    logic [CLR_W-1:0]   r_def_fg;
    logic [CLR_W-1:0]   r_def_bg;
    logic [CLR_W-1:0]   r_fg;
    logic [CLR_W-1:0]   r_bg;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [CA_W-1:0]    r_cnt;
    logic               r_cp_valid;
    logic [CA_W-1:0]    r_cp_addr;
    logic [CELL_W-1:0]  r_rdata;

    logic [FUNC_W-1:0]  r_func;
    logic [CHAR_W-1:0]  r_char;
    logic [COLOR_W-1:0] r_color;
    logic [CA_W-1:0]    r_addr;
    logic               r_in_range;

    logic                r_out_valid;
    logic [CUROFF_W-1:0] r_out_off;
    logic [CELL_W-1:0]   r_out_cell;
    logic [CLR_W-1:0]    r_out_fg;
    logic [CLR_W-1:0]    r_out_bg;

    logic [OFF_W-1:0]  w_offset;
    logic [CELL_W-1:0] w_char_cell;
    logic [CELL_W-1:0] w_fill_cell;
    logic [CA_W-1:0]   w_rd_addr;
    logic              w_rd_en;
    logic [CA_W-1:0]   w_cnt_start;

    assign w_offset    = OFF_W'(r_row) * OFF_W'(COLUMNS) + OFF_W'(r_col);
    assign w_char_cell = {r_bg, r_fg, r_char};
    assign w_fill_cell = i_cmd.fill_zero ? '0 : {r_bg, r_fg, CH_BLANK};
    assign w_rd_en     = i_cmd.copy || i_cmd.rd_cell;
    assign w_rd_addr   = i_cmd.copy ? r_cnt : r_addr;

    always_comb begin
        unique case (i_cmd.cnt_start)
            CS_ZERO:     w_cnt_start = '0;
            CS_COPY:     w_cnt_start = CA_W'(COLUMNS);
            CS_LAST_ROW: w_cnt_start = CA_W'((ROWS - 1) * COLUMNS);
            default:     w_cnt_start = '0;
        endcase
    end

    // cell store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (r_cp_valid) begin
            mem[r_cp_addr] <= r_rdata;
        end else if (i_cmd.fill) begin
            mem[r_cnt] <= w_fill_cell;
        end else if (i_cmd.put) begin
            mem[CA_W'(w_offset)] <= w_char_cell;
        end
        if (w_rd_en) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    // item fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func     <= i_func;
            r_char     <= i_char_code;
            r_color    <= i_color_code;
            r_addr     <= CA_W'(i_cell_address);
            r_in_range <= (32'(i_cell_address) < 32'(CELL_COUNT));
        end
        // copy write goes one row up, in the cycle after its read
        r_cp_addr <= r_cnt - CA_W'(COLUMNS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_fg    <= DEF_FG_RST;
            r_def_bg    <= DEF_BG_RST;
            r_fg        <= DEF_FG_RST;
            r_bg        <= DEF_BG_RST;
            r_row       <= '0;
            r_col       <= '0;
            r_cnt       <= '0;
            r_cp_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DEF_FG: r_def_fg <= i_cfg_wdata;
                    CFG_DEF_BG: r_def_bg <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end

            if (i_cmd.set_color) begin
                if (r_color[COLOR_W-1]) begin
                    r_bg <= r_color[CLR_W-1:0];
                end else begin
                    r_fg <= r_color[CLR_W-1:0];
                end
            end else if (i_cmd.defaults) begin
                r_fg <= r_def_fg;
                r_bg <= r_def_bg;
            end

            if (i_cmd.home) begin
                r_row <= '0;
                r_col <= '0;
            end else if (i_cmd.wrap) begin
                // on the last row the scroll keeps the cursor there
                if (r_row != ROW_W'(ROWS - 1)) begin
                    r_row <= r_row + 1'b1;
                end
                r_col <= '0;
            end else if (i_cmd.put) begin
                r_col <= r_col + 1'b1;
            end

            if (i_cmd.cnt_load) begin
                r_cnt <= w_cnt_start;
            end else if (i_cmd.copy || i_cmd.fill) begin
                r_cnt <= r_cnt + 1'b1;
            end

            r_cp_valid <= i_cmd.copy;

            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_off  <= CUROFF_W'(w_offset);
            r_out_cell <= (r_func == FN_READ && r_in_range) ? r_rdata : '0;
            r_out_fg   <= r_fg;
            r_out_bg   <= r_bg;
        end
    end

    assign o_stat.func     = r_func;
    assign o_stat.newline  = (r_char == CH_LF) || (r_char == CH_CR);
    assign o_stat.col_full = (r_col >= COL_W'(COLUMNS));
    assign o_stat.last_row = (r_row == ROW_W'(ROWS - 1));
    assign o_stat.cnt_last = (r_cnt == CA_W'(CELL_COUNT - 1));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_cursor_offset = r_out_off;
    assign o_cell_data     = r_out_cell;
    assign o_foreground    = r_out_fg;
    assign o_background    = r_out_bg;

    // the pending copy write owns the port: no other write may coincide
    a_copy_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_valid |-> !(i_cmd.fill || i_cmd.put))
        else $error("store write collides with scroll copy");

    // cursor column never passes the pending-wrap position
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_W'(COLUMNS))
        else $error("cursor column out of range");

    // a character is written only at a column inside the row
    a_put_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put |-> (r_col < COL_W'(COLUMNS)))
        else $error("character written past row end");

endmodule

`default_nettype wire
